// ----- hdl/g3n_pkg.sv -----
// Package for the 3D grid neighbour index generator.
// Field widths, register and direction codes, and the structs passed between stages.
// No dependencies.
package g3n_pkg;

  localparam int IDX_W      = 30;
  localparam int SIDE_W     = 11;
  localparam int COORD_W    = 10;
  localparam int PLANE_W    = 2 * SIDE_W;
  localparam int QBITS      = SIDE_W;
  localparam int CMP_W      = PLANE_W + QBITS;
  localparam int DIR_W      = 3;
  localparam int CNT_W      = 3;
  localparam int NUM_DIRS   = 6;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = 3;

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } reg_idx_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_LEFT    = 3'd0,
    DIR_RIGHT   = 3'd1,
    DIR_BOTTOM  = 3'd2,
    DIR_TOP     = 3'd3,
    DIR_CLOSER  = 3'd4,
    DIR_DISTANT = 3'd5
  } dir_t;

  // Clamped grid geometry; the user must keep it static while items are in flight, the block does not enforce this
  typedef struct packed {
    logic [SIDE_W-1:0]  sx;
    logic [SIDE_W-1:0]  sy;
    logic [SIDE_W-1:0]  sz;
    logic [PLANE_W-1:0] plane;
  } g3n_geom_t;

  // Item state through the divider stages
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] rem;
    logic [QBITS-1:0] qz;
    logic [QBITS-1:0] qy;
  } g3n_work_t;

  // Decoded cell with its candidate neighbours
  typedef struct packed {
    logic                               err;
    logic [NUM_DIRS-1:0]                ok;
    logic [NUM_DIRS-1:0][IDX_W-1:0]     nb;
    logic [COORD_W-1:0]                 cx;
    logic [COORD_W-1:0]                 cy;
    logic [COORD_W-1:0]                 cz;
    logic [CNT_W-1:0]                   cnt;
  } g3n_nbr_t;

  // One result item
  typedef struct packed {
    logic [IDX_W-1:0]   neighbour_index;
    logic [DIR_W-1:0]   direction;
    logic               has_neighbour;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic [CNT_W-1:0]   neighbour_count;
    logic               index_error;
    logic               last;
  } g3n_res_t;

endpackage

// ----- hdl/g3n_if.sv -----
// Stream interfaces for the query and result channels.
// Depends on g3n_pkg for field widths.
interface g3n_in_if import g3n_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] cell_index;

  modport source (output valid, output cell_index, input ready);
  modport sink   (input valid, input cell_index, output ready);
endinterface

interface g3n_out_if import g3n_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   neighbour_index;
  logic [DIR_W-1:0]   direction;
  logic               has_neighbour;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [COORD_W-1:0] coord_z;
  logic [CNT_W-1:0]   neighbour_count;
  logic               index_error;
  logic               last;

  modport source (output valid, output neighbour_index, output direction,
                  output has_neighbour, output coord_x, output coord_y,
                  output coord_z, output neighbour_count, output index_error,
                  output last, input ready);
  modport sink   (input valid, input neighbour_index, input direction,
                  input has_neighbour, input coord_x, input coord_y,
                  input coord_z, input neighbour_count, input index_error,
                  input last, output ready);
endinterface

// ----- hdl/grid3d_neighbour_index_generator_core.sv -----
// 3D grid 6-connected neighbour generator. A query passes the input register, six
// divider stages (four quotient bits each at most), the neighbour stage, the cell record
// and the output register. Queries enter the pipeline one per cycle unless it stalls;
// each query gives max(1, neighbour count) results, and the sustained rate is one
// result per cycle while the result port is not stalled.
// Synchronous reset sets the three sides to 1 and empties every stage; no clearing pass.
module grid3d_neighbour_index_generator_core import g3n_pkg::*; #(
  parameter int MAX_SIDE = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  g3n_in_if.sink            in_ch,
  g3n_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int NSTG = 2 * DIV_STAGES;

  g3n_geom_t geom;
  logic      st_v   [NSTG+1];
  logic      st_rdy [NSTG+1];
  g3n_work_t st_w   [NSTG+1];
  logic      v0_r;
  g3n_work_t w0_r;
  logic      nb_v;
  logic      nb_rdy;
  g3n_nbr_t  nb_d;

  g3n_cfg #(.MAX_SIDE(MAX_SIDE)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom    (geom)
  );

  // Capture the query; the remainder starts as the whole index
  assign in_ch.ready = !v0_r || st_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_ch.ready) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      w0_r.idx <= in_ch.cell_index;
      w0_r.rem <= in_ch.cell_index;
      w0_r.qz  <= '0;
      w0_r.qy  <= '0;
    end
  end

  assign st_v[0] = v0_r;
  assign st_w[0] = w0_r;

  // z by plane size first, then y by size_x on what remains
  for (genvar g = 0; g < NSTG; g++) begin : g_div
    localparam int PART = g % DIV_STAGES;
    g3n_div_stage #(
      .DO_Y  (g >= DIV_STAGES),
      .FIRST (QBITS - 1 - DIV_STEPS * PART),
      .STEPS ((PART == DIV_STAGES - 1) ? QBITS - DIV_STEPS * (DIV_STAGES - 1) : DIV_STEPS)
    ) u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .geom      (geom),
      .in_valid  (st_v[g]),
      .in_ready  (st_rdy[g]),
      .in_work   (st_w[g]),
      .out_valid (st_v[g+1]),
      .out_ready (st_rdy[g+1]),
      .out_work  (st_w[g+1])
    );
  end

  g3n_nbr u_nbr (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .in_valid  (st_v[NSTG]),
    .in_ready  (st_rdy[NSTG]),
    .in_work   (st_w[NSTG]),
    .out_valid (nb_v),
    .out_ready (nb_rdy),
    .out_nbr   (nb_d)
  );

  g3n_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (nb_v),
    .in_ready (nb_rdy),
    .in_nbr   (nb_d),
    .out_ch   (out_ch)
  );

endmodule

// ----- hdl/g3n_cfg.sv -----
// Size registers behind the APB-style port, with clamped sides and plane size.
// Depends on g3n_pkg.
module g3n_cfg import g3n_pkg::*; #(
  parameter int MAX_SIDE = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output g3n_geom_t         geom
);

  localparam logic [DATA_W-1:0] MAX_V = DATA_W'(MAX_SIDE);

  logic [SIDE_W-1:0]  size_x_r, size_y_r, size_z_r;
  logic [SIDE_W-1:0]  sx_r, sy_r, sz_r;
  logic [PLANE_W-1:0] plane_r;
  logic [SIDE_W-1:0]  wval;
  logic [SIDE_W-1:0]  wside;
  logic               wr_en;
  reg_idx_t           ridx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign ridx   = reg_idx_t'(paddr[3:2]);
  assign wval   = pwdata[SIDE_W-1:0];

  // On the low SIDE_W bits written, zero clamps to one and anything above the largest side saturates
  always_comb begin
    if (wval == '0) begin
      wside = SIDE_W'(1);
    end else if (DATA_W'(wval) > MAX_V) begin
      wside = MAX_V[SIDE_W-1:0];
    end else begin
      wside = wval;
    end
  end

  // Write raw and clamped copies; unknown addresses drop the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIDE_W'(1);
      size_y_r <= SIDE_W'(1);
      size_z_r <= SIDE_W'(1);
      sx_r     <= SIDE_W'(1);
      sy_r     <= SIDE_W'(1);
      sz_r     <= SIDE_W'(1);
    end else if (wr_en) begin
      unique case (ridx)
        REG_SIZE_X: begin
          size_x_r <= wval;
          sx_r     <= wside;
        end
        REG_SIZE_Y: begin
          size_y_r <= wval;
          sy_r     <= wside;
        end
        REG_SIZE_Z: begin
          size_z_r <= wval;
          sz_r     <= wside;
        end
        default: ;
      endcase
    end
  end

  // Plane size is registered from the clamped sides and follows them in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= PLANE_W'(1);
    end else begin
      plane_r <= PLANE_W'(sx_r) * PLANE_W'(sy_r);
    end
  end

  // Read back the raw register
  always_comb begin
    unique case (ridx)
      REG_SIZE_X: prdata = DATA_W'(size_x_r);
      REG_SIZE_Y: prdata = DATA_W'(size_y_r);
      REG_SIZE_Z: prdata = DATA_W'(size_z_r);
      default:    prdata = '0;
    endcase
  end

  assign geom.sx    = sx_r;
  assign geom.sy    = sy_r;
  assign geom.sz    = sz_r;
  assign geom.plane = plane_r;

endmodule

// ----- hdl/g3n_div_stage.sv -----
// One stage of the restoring divider: STEPS quotient bits per stage.
// Divides the running remainder by the plane size (z) or by size_x (y). Depends on g3n_pkg.
module g3n_div_stage import g3n_pkg::*; #(
  parameter bit DO_Y  = 1'b0,
  parameter int FIRST = 10,
  parameter int STEPS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  g3n_geom_t geom,
  input  logic      in_valid,
  output logic      in_ready,
  input  g3n_work_t in_work,
  output logic      out_valid,
  input  logic      out_ready,
  output g3n_work_t out_work
);

  logic               v_r;
  g3n_work_t          w_r;
  g3n_work_t          w_nxt;
  logic [PLANE_W-1:0] den;
  logic [CMP_W-1:0]   sh;

  assign den = DO_Y ? PLANE_W'(geom.sx) : geom.plane;

  // Compare and subtract the shifted divisor, one quotient bit a step
  always_comb begin
    w_nxt = in_work;
    sh    = '0;
    for (int i = 0; i < STEPS; i++) begin
      sh = CMP_W'(den) << (FIRST - i);
      if (CMP_W'(w_nxt.rem) >= sh) begin
        w_nxt.rem = w_nxt.rem - sh[IDX_W-1:0];
        if (DO_Y) begin
          w_nxt.qy[FIRST-i] = 1'b1;
        end else begin
          w_nxt.qz[FIRST-i] = 1'b1;
        end
      end
    end
  end

  // Advance when the next stage takes our item or we are empty
  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      w_r <= w_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_work  = w_r;

endmodule

// ----- hdl/g3n_nbr.sv -----
// Neighbour stage: range check, boundary flags, neighbour indices and count.
// Takes the divided item and the geometry. Depends on g3n_pkg.
module g3n_nbr import g3n_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  g3n_geom_t geom,
  input  logic      in_valid,
  output logic      in_ready,
  input  g3n_work_t in_work,
  output logic      out_valid,
  input  logic      out_ready,
  output g3n_nbr_t  out_nbr
);

  logic              v_r;
  g3n_nbr_t          n_r;
  g3n_nbr_t          n_nxt;
  logic [SIDE_W-1:0] x, y, z;
  logic              ovf;

  assign x = in_work.rem[SIDE_W-1:0];
  assign y = in_work.qy;
  assign z = in_work.qz;

  // Index beyond what the divider can resolve is out of range too
  assign ovf = CMP_W'(in_work.idx) >= {geom.plane, {QBITS{1'b0}}};

  always_comb begin
    n_nxt.err             = ovf || (z >= geom.sz);
    n_nxt.ok[DIR_LEFT]    = x != '0;
    n_nxt.ok[DIR_RIGHT]   = ((SIDE_W + 1)'(x) + (SIDE_W + 1)'(1)) < (SIDE_W + 1)'(geom.sx);
    n_nxt.ok[DIR_BOTTOM]  = y != '0;
    n_nxt.ok[DIR_TOP]     = ((SIDE_W + 1)'(y) + (SIDE_W + 1)'(1)) < (SIDE_W + 1)'(geom.sy);
    n_nxt.ok[DIR_CLOSER]  = z != '0;
    n_nxt.ok[DIR_DISTANT] = ((SIDE_W + 1)'(z) + (SIDE_W + 1)'(1)) < (SIDE_W + 1)'(geom.sz);
    n_nxt.nb[DIR_LEFT]    = in_work.idx - IDX_W'(1);
    n_nxt.nb[DIR_RIGHT]   = in_work.idx + IDX_W'(1);
    n_nxt.nb[DIR_BOTTOM]  = in_work.idx - IDX_W'(geom.sx);
    n_nxt.nb[DIR_TOP]     = in_work.idx + IDX_W'(geom.sx);
    n_nxt.nb[DIR_CLOSER]  = in_work.idx - IDX_W'(geom.plane);
    n_nxt.nb[DIR_DISTANT] = in_work.idx + IDX_W'(geom.plane);
    n_nxt.cx              = x[COORD_W-1:0];
    n_nxt.cy              = y[COORD_W-1:0];
    n_nxt.cz              = z[COORD_W-1:0];
    n_nxt.cnt             = CNT_W'($countones(n_nxt.ok));
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      n_r <= n_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_nbr   = n_r;

endmodule

// ----- hdl/g3n_emit.sv -----
// Result emitter: walks the neighbour mask of one cell, one result per cycle while the output is not stalled.
// Holds one cell record and the output register. Depends on g3n_pkg and g3n_if.
module g3n_emit import g3n_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  g3n_nbr_t         in_nbr,
  g3n_out_if.source        out_ch
);

  logic                rec_v_r;
  g3n_nbr_t            rec_r;
  logic [NUM_DIRS-1:0] mask_r;
  logic                spec_r;
  logic                out_valid_r;
  g3n_res_t            res_r;
  g3n_res_t            res_nxt;
  logic [DIR_W-1:0]    d_sel;
  logic [NUM_DIRS-1:0] mask_left;
  logic                is_last;
  logic                adv;
  logic                spec_in;

  // Pick the lowest pending direction
  always_comb begin
    d_sel = DIR_W'(0);
    for (int i = NUM_DIRS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        d_sel = DIR_W'(i);
      end
    end
  end

  assign mask_left = mask_r & ~(NUM_DIRS'(1) << d_sel);
  assign is_last   = mask_left == '0;
  assign adv       = rec_v_r && (!out_valid_r || out_ch.ready);
  assign in_ready  = !rec_v_r || (adv && is_last);

  // Out-of-range and isolated cells give a single result
  assign spec_in   = in_nbr.err || (in_nbr.ok == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_v_r <= 1'b0;
    end else if (in_ready && in_valid) begin
      rec_v_r <= 1'b1;
    end else if (adv && is_last) begin
      rec_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rec_r  <= in_nbr;
      spec_r <= spec_in;
      mask_r <= spec_in ? NUM_DIRS'(1) : in_nbr.ok;
    end else if (adv) begin
      mask_r <= mask_left;
    end
  end

  // Build the result for the selected direction
  always_comb begin
    if (spec_r) begin
      res_nxt.neighbour_index = '0;
      res_nxt.direction       = DIR_LEFT;
      res_nxt.has_neighbour   = 1'b0;
      res_nxt.coord_x         = rec_r.err ? '0 : rec_r.cx;
      res_nxt.coord_y         = rec_r.err ? '0 : rec_r.cy;
      res_nxt.coord_z         = rec_r.err ? '0 : rec_r.cz;
      res_nxt.neighbour_count = '0;
      res_nxt.index_error     = rec_r.err;
      res_nxt.last            = 1'b1;
    end else begin
      res_nxt.neighbour_index = rec_r.nb[d_sel];
      res_nxt.direction       = d_sel;
      res_nxt.has_neighbour   = 1'b1;
      res_nxt.coord_x         = rec_r.cx;
      res_nxt.coord_y         = rec_r.cy;
      res_nxt.coord_z         = rec_r.cz;
      res_nxt.neighbour_count = rec_r.cnt;
      res_nxt.index_error     = 1'b0;
      res_nxt.last            = is_last;
    end
  end

  // Output register: load on advance, drop once the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.neighbour_index = res_r.neighbour_index;
  assign out_ch.direction       = res_r.direction;
  assign out_ch.has_neighbour   = res_r.has_neighbour;
  assign out_ch.coord_x         = res_r.coord_x;
  assign out_ch.coord_y         = res_r.coord_y;
  assign out_ch.coord_z         = res_r.coord_z;
  assign out_ch.neighbour_count = res_r.neighbour_count;
  assign out_ch.index_error     = res_r.index_error;
  assign out_ch.last            = res_r.last;

endmodule
